@@ sv/fcnt_pkg.sv @@
// types and constants shared by the flow counter table
package fcnt_pkg;

   localparam int ENTRIES_DEFAULT = 256;
   localparam int INDEX_W         = 8;
   localparam int BYTE_ADD_W      = 32;
   localparam int COUNT_W         = 64;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_ADJUST = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef struct packed {
      logic [1:0]            op;
      logic [INDEX_W-1:0]    index;
      logic [BYTE_ADD_W-1:0] byte_add;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [COUNT_W-1:0] packet_count;
      logic [COUNT_W-1:0] byte_count;
   } rsp_type;

endpackage

@@ sv/flow_counter_table.sv @@
// flow counter table: per-entry packet and byte counters in one memory
//
// Each entry holds a 64-bit packet count and a 64-bit byte count in a single
// synchronous memory row with a registered read. One transaction is
// worked on at a time. An adjust or read has its row read at the accepting
// edge into a read register, and the table moves to the lookup state. There,
// once the response register is free, the row is written back (adjust) or
// loaded into the response register (read), and no new transaction is taken
// until that is done. A clear walks the memory one row per cycle and then
// gives its acknowledgement. After reset the same clearing pass runs before
// the first transaction is taken. An adjust or read whose index lies beyond
// the table leaves the memory alone and answers with an acknowledgement or a
// zero report; op code 3 is taken and dropped.
module flow_counter_table #(
   parameter int ENTRIES = fcnt_pkg::ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fcnt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fcnt_pkg::rsp_type rsp_data
);
   import fcnt_pkg::*;

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int WIDE_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
   localparam int ROW_W  = 2 * COUNT_W;
   localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(ENTRIES - 1);

   typedef enum logic [4:0] {
      ST_INIT   = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_LOOKUP = 5'b00100,
      ST_CLEAR  = 5'b01000,
      ST_ACK    = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      sweep_ff, sweep_in;
   logic [1:0]            op_ff;
   logic [IDX_W-1:0]      addr_ff;
   logic                  hit_ff;
   logic [BYTE_ADD_W-1:0] amount_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [ROW_W-1:0]      rd_data_ff;

   logic [ROW_W-1:0] mem [ENTRIES];

   logic [WIDE_W-1:0] index_wide;
   logic [IDX_W-1:0]  req_addr;
   logic              req_hit;
   logic              accept;
   logic              out_free;
   logic              rd_en;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ROW_W-1:0]  wr_data;
   logic [COUNT_W-1:0] pkt_sum;
   logic [COUNT_W-1:0] byte_sum;

   assign index_wide = WIDE_W'(req_data.index);
   assign req_addr   = index_wide[IDX_W-1:0];
   assign req_hit    = ((WIDE_W + 1)'(req_data.index) < (WIDE_W + 1)'(ENTRIES));
   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rd_en      = accept;

   assign pkt_sum  = rd_data_ff[ROW_W-1:COUNT_W] + COUNT_W'(1);
   assign byte_sum = rd_data_ff[COUNT_W-1:0] + COUNT_W'(amount_ff);

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = sweep_ff;
      wr_data      = '0;
      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            wr_en    = 1'b1;
            sweep_in = sweep_ff + IDX_W'(1);
            if (sweep_ff == LAST_ROW) begin
               sweep_in = '0;
               state_in = (state_ff == ST_CLEAR) ? ST_ACK : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.op)
                  OP_CLEAR:  state_in = ST_CLEAR;
                  OP_ADJUST: state_in = ST_LOOKUP;
                  OP_READ:   state_in = ST_LOOKUP;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (op_ff == OP_READ) begin
                  rsp_in.kind = KIND_REPORT;
                  if (hit_ff) begin
                     rsp_in.packet_count = rd_data_ff[ROW_W-1:COUNT_W];
                     rsp_in.byte_count   = rd_data_ff[COUNT_W-1:0];
                  end else begin
                     rsp_in.packet_count = '0;
                     rsp_in.byte_count   = '0;
                  end
               end else begin
                  rsp_in.kind         = KIND_ACK;
                  rsp_in.packet_count = '0;
                  rsp_in.byte_count   = '0;
                  wr_en               = hit_ff;
                  wr_addr             = addr_ff;
                  wr_data             = {pkt_sum, byte_sum};
               end
            end
         end
         ST_ACK: begin
            if (out_free) begin
               state_in            = ST_IDLE;
               rsp_valid_in        = 1'b1;
               rsp_in.kind         = KIND_ACK;
               rsp_in.packet_count = '0;
               rsp_in.byte_count   = '0;
            end
         end
         default: begin
            state_in = ST_INIT;
            sweep_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         op_ff     <= req_data.op;
         addr_ff   <= req_addr;
         hit_ff    <= req_hit;
         amount_ff <= req_data.byte_add;
      end
   end

   // counter memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[req_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_lookup_after_access : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.op == OP_ADJUST || req_data.op == OP_READ))
      |=> (state_ff == ST_LOOKUP))
      else $error("adjust or read not followed by lookup");

   a_sweep_after_clear : assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.op == OP_CLEAR) |=> (state_ff == ST_CLEAR && sweep_ff == '0))
      else $error("clear did not start a sweep at row zero");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_LOOKUP || $past(state_ff) == ST_ACK))
      else $error("response raised outside lookup or acknowledge");

   a_ack_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_ACK)
      |-> (rsp_ff.packet_count == '0 && rsp_ff.byte_count == '0))
      else $error("acknowledgement carries nonzero counts");
`endif

endmodule
